// File: hw/rtl/arrive_steering_accel_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arrive steering accelerator
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ARRIVE_STEERING_ACCEL_TOP_ASSERT_SVH
`define ARRIVE_STEERING_ACCEL_TOP_ASSERT_SVH

// Same-cycle implication
`define ASA_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("steering assertion failed");

// Next-cycle implication
`define ASA_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("steering assertion failed");

`endif

// File: hw/rtl/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// Shared widths, sequencer states and control types of the steering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asa_pkg;

    localparam int COORD_W = 24;            // coordinate word
    localparam int MAG_W   = COORD_W - 1;   // unsigned config magnitudes
    localparam int GAIN_W  = 9;             // Q1.8 gain
    localparam int GAIN_FRAC = 8;
    localparam int OP_W    = COORD_W + 1;   // magnitudes of differences
    localparam int PROD_W  = 2 * OP_W;      // multiplier product
    localparam int REM_W   = 30;            // iterative unit remainder
    localparam int CNT_W   = 5;
    localparam int SQRT_STEPS = OP_W;       // result bits of a root
    localparam int DIV_STEPS  = COORD_W;    // quotient bits of a division
    localparam int IDX_W   = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ACCEL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STOP_RADIUS = 3'd2;
    localparam logic [IDX_W-1:0] REG_SLOW_RADIUS = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN        = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_LEN_GO, S_LEN_WAIT,
        S_SPD_MUL, S_SPD_GO, S_SPD_WAIT,
        S_DX_MUL, S_DX_GO, S_DX_WAIT, S_DY_MUL, S_DY_GO, S_DY_WAIT,
        S_DES,
        S_CX_MUL, S_CX_GO, S_CX_WAIT, S_CY_MUL, S_CY_GO, S_CY_WAIT,
        S_GX, S_GY, S_OUT
    } asa_state_t;

    // Request to the shared root/divide unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } asa_op_t;

endpackage

// File: hw/rtl/asa_iter.sv
// ----------------------------------------------------------------------------
// asa_iter
// Shared bit-serial unit: integer square root or restoring division,
// one result bit per cycle through a single compare-subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asa_iter
    import asa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  asa_op_t           op,
    input  logic [PROD_W-1:0] num,      // radicand, or dividend in low 48 bits
    input  logic [OP_W-1:0]   den,
    output logic              busy,
    output logic              done,
    output logic [OP_W-1:0]   result
);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [OP_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0] src_reg;
    logic [OP_W-1:0]   den_reg;
    logic              sqrt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // One compare-subtract step
    always_comb begin
        if (sqrt_reg) begin
            shifted = {rem_reg[REM_W-3:0], src_reg[PROD_W-1 -: 2]};
            trial   = {{(REM_W-OP_W-2){1'b0}}, acc_reg, 2'b01};
        end else begin
            shifted = {rem_reg[REM_W-2:0], src_reg[PROD_W-1]};
            trial   = {{(REM_W-OP_W){1'b0}}, den_reg};
        end
        ge       = shifted >= trial;
        rem_next = ge ? shifted - trial : shifted;
        acc_next = {acc_reg[OP_W-2:0], ge};
    end

    // Load on request, then advance one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (op.start) begin
                sqrt_reg <= op.is_sqrt;
                den_reg  <= den;
                acc_reg  <= '0;
                if (op.is_sqrt) begin
                    src_reg <= num;
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(SQRT_STEPS);
                end else begin
                    src_reg <= {num[DIV_STEPS-1:0], {(PROD_W-DIV_STEPS){1'b0}}};
                    rem_reg <= {{(REM_W-DIV_STEPS){1'b0}}, num[2*DIV_STEPS-1:DIV_STEPS]};
                    cnt_reg <= CNT_W'(DIV_STEPS);
                end
            end else if (cnt_reg != '0) begin
                rem_reg <= rem_next;
                acc_reg <= acc_next;
                src_reg <= sqrt_reg ? (src_reg << 2) : (src_reg << 1);
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy   = cnt_reg != '0;
    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// File: hw/rtl/arrive_steering_accel_top.sv
// Each request is sequenced through the bit-serial root/divide unit: two lengths, each
// after its squares, and up to five divisions, each after its product; the slowdown
// division and the two clamp divisions run only when needed, and once the agent has
// arrived only the first length is computed.
// The input is not ready while a request is in flight, so one request is handled at a time.
// Reset (aresetn low, synchronous): arrival latch cleared, limits zero, gain one.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrive_steering_accel_top
// Arrive steering: offset length, speed ramp, velocity difference, length
// clamp and gain, sequenced over one multiplier and one root/divide unit.
// ----------------------------------------------------------------------------

module arrive_steering_accel_top
    import asa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // goal_x, goal_y, pos_x, pos_y, vel_x, vel_y
    input  logic [143:0]     s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // accel_x, accel_y, has_arrived, zero pad
    output logic [55:0]      m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [MAG_W-1:0] cfg_data
);

    asa_state_t state_reg, state_next;

    logic [MAG_W-1:0]  max_speed_reg, max_accel_reg, stop_reg, slow_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              arrived_reg;

    logic [OP_W-1:0]   ux_reg, uy_reg;
    logic              sx_reg, sy_reg;
    logic [COORD_W-1:0] vx_reg, vy_reg;
    logic              phase_reg;
    logic [OP_W-1:0]   len_reg;
    logic [OP_W-1:0]   speed_reg;
    logic [OP_W-1:0]   qx_reg, qy_reg;
    logic [PROD_W-1:0] prod_reg, sum_reg, gx_reg;
    logic              m_valid_reg;
    logic [55:0]       m_data_reg;

    logic [OP_W-1:0]   mul_a, mul_b;
    asa_op_t           unit_op;
    logic [PROD_W-1:0] unit_num;
    logic [OP_W-1:0]   unit_den;
    logic              unit_busy, unit_done;
    logic [OP_W-1:0]   unit_res;

    logic              in_fire, out_free;
    logic signed [OP_W-1:0] dx, dy;
    logic signed [OP_W:0]   ax, ay;
    logic              far_stop, in_slow, over_accel;
    logic [COORD_W-1:0] sat_x, sat_y;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign dx = OP_W'(signed'(s_tdata[23:0])) - OP_W'(signed'(s_tdata[71:48]));
    assign dy = OP_W'(signed'(s_tdata[47:24])) - OP_W'(signed'(s_tdata[95:72]));

    // Desired velocity minus current velocity
    assign ax = (sx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg}))
              - (OP_W+1)'(signed'(vx_reg));
    assign ay = (sy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg}))
              - (OP_W+1)'(signed'(vy_reg));

    assign far_stop   = !(unit_res < OP_W'(stop_reg));
    assign in_slow    = unit_res < OP_W'(slow_reg);
    assign over_accel = unit_res > OP_W'(max_accel_reg);

    // Saturate a gain product back to the coordinate range
    function automatic logic [COORD_W-1:0] sat_out(input logic [PROD_W-1:0] p,
                                                  input logic neg);
        logic [PROD_W-GAIN_FRAC-1:0] m;
        m = p[PROD_W-1:GAIN_FRAC];
        if (neg) begin
            if (m > (PROD_W-GAIN_FRAC)'(1 << (COORD_W-1))) begin
                sat_out = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                sat_out = -m[COORD_W-1:0];
            end
        end else begin
            if (m > (PROD_W-GAIN_FRAC)'((1 << (COORD_W-1)) - 1)) begin
                sat_out = {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                sat_out = m[COORD_W-1:0];
            end
        end
    endfunction

    assign sat_x = sat_out(gx_reg, sx_reg);
    assign sat_y = sat_out(prod_reg, sy_reg);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= '0;
            max_accel_reg <= '0;
            stop_reg      <= '0;
            slow_reg      <= '0;
            gain_reg      <= GAIN_W'(1 << GAIN_FRAC);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_SPEED:   max_speed_reg <= cfg_data;
                REG_MAX_ACCEL:   max_accel_reg <= cfg_data;
                REG_STOP_RADIUS: stop_reg      <= cfg_data;
                REG_SLOW_RADIUS: slow_reg      <= cfg_data;
                REG_GAIN:        gain_reg      <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_fire) state_next = S_SQX;
            S_SQX:      state_next = S_SQY;
            S_SQY:      state_next = S_LEN_GO;
            S_LEN_GO:   state_next = S_LEN_WAIT;
            S_LEN_WAIT: begin
                if (unit_done) begin
                    if (phase_reg) begin
                        state_next = over_accel ? S_CX_MUL : S_GX;
                    end else if (arrived_reg || !far_stop) begin
                        state_next = S_OUT;
                    end else if (in_slow) begin
                        state_next = S_SPD_MUL;
                    end else begin
                        state_next = (unit_res != '0) ? S_DX_MUL : S_DES;
                    end
                end
            end
            S_SPD_MUL:  state_next = S_SPD_GO;
            S_SPD_GO:   state_next = S_SPD_WAIT;
            S_SPD_WAIT: if (unit_done) state_next = (len_reg != '0) ? S_DX_MUL : S_DES;
            S_DX_MUL:   state_next = S_DX_GO;
            S_DX_GO:    state_next = S_DX_WAIT;
            S_DX_WAIT:  if (unit_done) state_next = S_DY_MUL;
            S_DY_MUL:   state_next = S_DY_GO;
            S_DY_GO:    state_next = S_DY_WAIT;
            S_DY_WAIT:  if (unit_done) state_next = S_DES;
            S_DES:      state_next = S_SQX;
            S_CX_MUL:   state_next = S_CX_GO;
            S_CX_GO:    state_next = S_CX_WAIT;
            S_CX_WAIT:  if (unit_done) state_next = S_CY_MUL;
            S_CY_MUL:   state_next = S_CY_GO;
            S_CY_GO:    state_next = S_CY_WAIT;
            S_CY_WAIT:  if (unit_done) state_next = S_GX;
            S_GX:       state_next = S_GY;
            S_GY:       state_next = S_OUT;
            S_OUT:      if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Multiplier operands and unit requests
    always_comb begin
        mul_a    = ux_reg;
        mul_b    = ux_reg;
        unit_op  = '0;
        unit_num = prod_reg;
        unit_den = len_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:    s_tready = 1'b1;
            S_SQY:     begin mul_a = uy_reg; mul_b = uy_reg; end
            S_LEN_GO:  begin
                unit_op  = '{start: 1'b1, is_sqrt: 1'b1};
                unit_num = sum_reg + prod_reg;
            end
            S_SPD_MUL: begin mul_a = OP_W'(max_speed_reg); mul_b = len_reg; end
            S_SPD_GO:  begin
                unit_op  = '{start: 1'b1, is_sqrt: 1'b0};
                unit_den = OP_W'(slow_reg);
            end
            S_DX_MUL:  mul_b = speed_reg;
            S_DY_MUL:  begin mul_a = uy_reg; mul_b = speed_reg; end
            S_CX_MUL:  mul_b = OP_W'(max_accel_reg);
            S_CY_MUL:  begin mul_a = uy_reg; mul_b = OP_W'(max_accel_reg); end
            S_DX_GO, S_DY_GO, S_CX_GO, S_CY_GO:
                unit_op = '{start: 1'b1, is_sqrt: 1'b0};
            S_GX:      mul_b = OP_W'(gain_reg);
            S_GY, S_OUT: begin mul_a = uy_reg; mul_b = OP_W'(gain_reg); end
            default: ;
        endcase
    end

    // Shared multiplier, registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    ux_reg    <= dx[OP_W-1] ? OP_W'(-dx) : OP_W'(dx);
                    uy_reg    <= dy[OP_W-1] ? OP_W'(-dy) : OP_W'(dy);
                    sx_reg    <= dx[OP_W-1];
                    sy_reg    <= dy[OP_W-1];
                    vx_reg    <= s_tdata[119:96];
                    vy_reg    <= s_tdata[143:120];
                    phase_reg <= 1'b0;
                end
            end
            S_SQY: sum_reg <= prod_reg;
            S_LEN_WAIT: begin
                if (unit_done) begin
                    len_reg   <= unit_res;
                    speed_reg <= OP_W'(max_speed_reg);
                    qx_reg    <= '0;
                    qy_reg    <= '0;
                end
            end
            S_SPD_WAIT: if (unit_done) speed_reg <= unit_res;
            S_DX_WAIT:  if (unit_done) qx_reg <= unit_res;
            S_DY_WAIT:  if (unit_done) qy_reg <= unit_res;
            S_DES: begin
                ux_reg    <= ax[OP_W] ? OP_W'(-ax) : OP_W'(ax);
                uy_reg    <= ay[OP_W] ? OP_W'(-ay) : OP_W'(ay);
                sx_reg    <= ax[OP_W];
                sy_reg    <= ay[OP_W];
                phase_reg <= 1'b1;
            end
            S_CX_WAIT: if (unit_done) ux_reg <= unit_res;
            S_CY_WAIT: if (unit_done) uy_reg <= unit_res;
            S_GY:      gx_reg <= prod_reg;
            default: ;
        endcase
    end

    // Sequencer, arrival latch and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            arrived_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_LEN_WAIT && unit_done && !phase_reg && !far_stop) begin
                arrived_reg <= 1'b1;
            end
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                if (arrived_reg) begin
                    m_data_reg <= {7'd0, 1'b1, {(2*COORD_W){1'b0}}};
                end else begin
                    m_data_reg <= {7'd0, 1'b0, sat_y, sat_x};
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    asa_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (unit_op),
        .num     (unit_num),
        .den     (unit_den),
        .busy    (unit_busy),
        .done    (unit_done),
        .result  (unit_res)
    );

`include "arrive_steering_accel_top_assert.svh"

    `ASA_NEXT(a_latch_sticky, arrived_reg, arrived_reg)
    `ASA_IMPLIES(a_arrived_zero, m_tvalid && m_tdata[48], m_tdata[47:0] == 48'd0)
    `ASA_IMPLIES(a_no_restart, unit_op.start, !unit_busy)
    `ASA_NEXT(a_busy_after_req, in_fire, !s_tready)

endmodule
